### rtl/ccp_pkg.sv
// Shared types, tag codes and decode functions for the constant pool parser.
// Used by ccp_in_stage, ccp_parse, ccp_out_stage and the top level.
package ccp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_COUNT_LO = 3'd1,
        PH_TAG      = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_TEXT     = 3'd4
    } phase_t;

    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELD_REF     = 8'd9;
    localparam logic [7:0] TAG_METHOD_REF    = 8'd10;
    localparam logic [7:0] TAG_IFACE_REF     = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;

    typedef struct packed {
        logic [15:0] slot_number;
        logic [7:0]  entry_tag;
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic [63:0] raw_value;
        logic [7:0]  text_byte;
        logic        text_valid;
        logic        entry_last;
        logic        bad_tag;
        logic        pool_last;
    } result_t;

    // Payload length in bytes for a tag; zero marks an unknown tag.
    function automatic logic [3:0] payload_len(input logic [7:0] tag);
        logic [3:0] len;
        case (tag) inside
            TAG_UTF8:                               len = 4'd2;
            TAG_INTEGER, TAG_FLOAT:                 len = 4'd4;
            TAG_LONG, TAG_DOUBLE:                   len = 4'd8;
            TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: len = 4'd2;
            TAG_FIELD_REF, TAG_METHOD_REF,
            TAG_IFACE_REF, TAG_NAME_AND_TYPE:       len = 4'd4;
            TAG_METHOD_HANDLE:                      len = 4'd3;
            default:                                len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/ccp_in_stage.sv
// Input register of the constant pool parser: holds one accepted stream word.
// Depends on ccp_pkg.
module ccp_in_stage
    import ccp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_pool_start,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_start
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= s_data_byte;
            start_reg <= s_pool_start;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_start = start_reg;

endmodule

### rtl/ccp_parse.sv
// Parser state machine: takes one stream word per step and forms at most one result.
// Depends on ccp_pkg.
module ccp_parse
    import ccp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       pool_start,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] slots_left_reg, slots_left_next;
    logic [15:0] slot_counter_reg, slot_counter_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [63:0] asm_reg, asm_next;
    logic [15:0] held_first_reg, held_first_next;

    logic [15:0] count;
    logic [3:0]  tag_len;
    logic [63:0] asm_shift;
    logic [15:0] bytes_dec;
    logic [7:0]  fin_tag;
    logic [1:0]  fin_used;
    logic        fin_end;
    logic        payload_done;
    logic        text_start;

    assign count        = {asm_reg[7:0], data_byte};
    assign tag_len      = payload_len(data_byte);
    assign asm_shift    = {asm_reg[55:0], data_byte};
    assign bytes_dec    = bytes_left_reg - 16'd1;
    assign payload_done = (bytes_dec == 16'd0);
    assign text_start   = (current_tag_reg == TAG_UTF8) && (asm_shift[15:0] != 16'd0);

    // The entry that closes in this step carries the new tag when it closes on the tag word.
    assign fin_tag  = (phase_reg == PH_TAG) ? data_byte : current_tag_reg;
    assign fin_used = (fin_tag == TAG_LONG || fin_tag == TAG_DOUBLE) ? 2'd2 : 2'd1;
    assign fin_end  = (slots_left_reg <= {14'd0, fin_used});

    always_comb begin
        phase_next = phase_reg;
        if (pool_start) begin
            phase_next = PH_COUNT_LO;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_COUNT_LO: begin
                    phase_next = (count <= 16'd1) ? PH_IDLE : PH_TAG;
                end
                PH_TAG: begin
                    if (tag_len != 4'd0) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next = fin_end ? PH_IDLE : PH_TAG;
                    end
                end
                PH_PAYLOAD: begin
                    if (payload_done) begin
                        if (text_start) begin
                            phase_next = PH_TEXT;
                        end else begin
                            phase_next = fin_end ? PH_IDLE : PH_TAG;
                        end
                    end
                end
                PH_TEXT: begin
                    if (payload_done) begin
                        phase_next = fin_end ? PH_IDLE : PH_TAG;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        logic close_entry;
        close_entry       = 1'b0;
        slots_left_next   = slots_left_reg;
        slot_counter_next = slot_counter_reg;
        current_tag_next  = current_tag_reg;
        bytes_left_next   = bytes_left_reg;
        asm_next          = asm_reg;
        held_first_next   = held_first_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (pool_start) begin
            asm_next = {56'd0, data_byte};
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_COUNT_LO: begin
                    asm_next = '0;
                    if (count <= 16'd1) begin
                        slots_left_next = '0;
                    end else begin
                        slots_left_next   = count - 16'd1;
                        slot_counter_next = 16'd1;
                    end
                end
                PH_TAG: begin
                    current_tag_next = data_byte;
                    asm_next         = '0;
                    if (tag_len == 4'd0) begin
                        res_valid       = 1'b1;
                        res.slot_number = slot_counter_reg;
                        res.entry_tag   = data_byte;
                        res.entry_last  = 1'b1;
                        res.bad_tag     = 1'b1;
                        close_entry     = 1'b1;
                    end else begin
                        bytes_left_next = {12'd0, tag_len};
                    end
                end
                PH_PAYLOAD: begin
                    asm_next        = asm_shift;
                    bytes_left_next = bytes_dec;
                    if (payload_done) begin
                        if (current_tag_reg == TAG_UTF8) begin
                            held_first_next = asm_shift[15:0];
                        end
                        if (text_start) begin
                            bytes_left_next = asm_shift[15:0];
                        end else begin
                            res_valid       = 1'b1;
                            res.slot_number = slot_counter_reg;
                            res.entry_tag   = current_tag_reg;
                            res.entry_last  = 1'b1;
                            close_entry     = 1'b1;
                            case (current_tag_reg) inside
                                TAG_INTEGER, TAG_FLOAT: begin
                                    res.raw_value = {32'd0, asm_shift[31:0]};
                                end
                                TAG_LONG, TAG_DOUBLE: begin
                                    res.raw_value = asm_shift;
                                end
                                TAG_FIELD_REF, TAG_METHOD_REF,
                                TAG_IFACE_REF, TAG_NAME_AND_TYPE: begin
                                    res.first_index  = asm_shift[31:16];
                                    res.second_index = asm_shift[15:0];
                                end
                                TAG_METHOD_HANDLE: begin
                                    res.first_index  = asm_shift[15:0];
                                    res.second_index = {8'd0, asm_shift[23:16]};
                                end
                                default: begin
                                    res.first_index = asm_shift[15:0];
                                end
                            endcase
                        end
                    end
                end
                PH_TEXT: begin
                    bytes_left_next = bytes_dec;
                    res_valid       = 1'b1;
                    res.slot_number = slot_counter_reg;
                    res.entry_tag   = current_tag_reg;
                    res.first_index = held_first_reg;
                    res.text_byte   = data_byte;
                    res.text_valid  = 1'b1;
                    if (payload_done) begin
                        res.entry_last = 1'b1;
                        close_entry    = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (close_entry) begin
                res.pool_last = fin_end;
                if (fin_end) begin
                    slots_left_next = '0;
                end else begin
                    slots_left_next   = slots_left_reg - {14'd0, fin_used};
                    slot_counter_next = slot_counter_reg + {14'd0, fin_used};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            slots_left_reg   <= '0;
            slot_counter_reg <= '0;
            current_tag_reg  <= '0;
            bytes_left_reg   <= '0;
            asm_reg          <= '0;
            held_first_reg   <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            slots_left_reg   <= slots_left_next;
            slot_counter_reg <= slot_counter_next;
            current_tag_reg  <= current_tag_next;
            bytes_left_reg   <= bytes_left_next;
            asm_reg          <= asm_next;
            held_first_reg   <= held_first_next;
        end
    end

endmodule

### rtl/ccp_out_stage.sv
// Result register of the constant pool parser, holding one word until it is taken.
// Depends on ccp_pkg.
module ccp_out_stage
    import ccp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign held    = data_reg;

endmodule

### rtl/class_constant_pool_parser_core.sv
// Constant pool parser: one stream byte per word in, at most one result word out.
// A word passes from the input register through the combinational parse step
// into the result register; a full result register holds it in the input register.
// Throughput: one input word per cycle, set by the single parse step between registers.
// A full result register stalls the input only until that result is taken.
// Reset (aresetn low, synchronous) empties both registers and waits for a pool start.
module class_constant_pool_parser_core
    import ccp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_pool_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_slot_number,
    output logic [7:0]  m_entry_tag,
    output logic [15:0] m_first_index,
    output logic [15:0] m_second_index,
    output logic [63:0] m_raw_value,
    output logic [7:0]  m_text_byte,
    output logic        m_text_valid,
    output logic        m_entry_last,
    output logic        m_bad_tag,
    output logic        m_pool_last
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_start;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_word;

    // A held word is parsed once the result register is free or being emptied.
    assign advance = held_valid && (!m_valid || m_ready);

    ccp_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_pool_start (s_pool_start),
        .advance      (advance),
        .held_valid   (held_valid),
        .held_byte    (held_byte),
        .held_start   (held_start)
    );

    ccp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .data_byte  (held_byte),
        .pool_start (held_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    ccp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .held    (out_word)
    );

    assign m_slot_number  = out_word.slot_number;
    assign m_entry_tag    = out_word.entry_tag;
    assign m_first_index  = out_word.first_index;
    assign m_second_index = out_word.second_index;
    assign m_raw_value    = out_word.raw_value;
    assign m_text_byte    = out_word.text_byte;
    assign m_text_valid   = out_word.text_valid;
    assign m_entry_last   = out_word.entry_last;
    assign m_bad_tag      = out_word.bad_tag;
    assign m_pool_last    = out_word.pool_last;

endmodule
